### design/srsp_pkg.sv
// shared types, constants and codes for the shifted row-sum projection block
package srsp_pkg;

  // parameter defaults
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int PIXEL_BITS_DEF  = 16;

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 6;
  localparam int PIX_W    = 16;
  localparam int SHIFT_W  = 12;
  localparam int PROJ_W   = 30;
  localparam int STATUS_W = 2;
  localparam int NCOL_W   = 11;
  localparam int NROW_W   = 7;

  // apb port
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;

  // arithmetic widths: at most 64 rows are walked, so a 7 bit count holds them
  localparam int ROWCNT_W  = 7;
  localparam int SUM_EXTRA = 6;
  localparam int FRAC_BITS = 8;

  localparam logic [PROJ_W-1:0] PROJ_MAX = {PROJ_W{1'b1}};

  // register reset values
  localparam logic [ROW_W-1:0]  RESET_ROW_FIRST = 6'd5;
  localparam logic [ROW_W-1:0]  RESET_ROW_LAST  = 6'd58;
  localparam logic [NCOL_W-1:0] RESET_COLUMNS   = 11'd1024;
  localparam logic [NROW_W-1:0] RESET_ROWS      = 7'd64;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ROW_FIRST = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_LAST  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLUMNS   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROWS      = 2'd3;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SHIFT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_COL   = 2'd2;

  typedef struct packed {
    logic [ROW_W-1:0]  row_first;
    logic [ROW_W-1:0]  row_last;
    logic [NCOL_W-1:0] columns_in_use;
    logic [NROW_W-1:0] rows_in_use;
  } cfg_t;

endpackage

### design/srsp_regs.sv
// apb configuration registers of the projection block
module srsp_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srsp_pkg::ADDR_W-1:0] paddr,
  input  logic [srsp_pkg::DATA_W-1:0] pwdata,
  output logic [srsp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output srsp_pkg::cfg_t              cfg
);
  import srsp_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_first      <= RESET_ROW_FIRST;
      cfg.row_last       <= RESET_ROW_LAST;
      cfg.columns_in_use <= RESET_COLUMNS;
      cfg.rows_in_use    <= RESET_ROWS;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROW_FIRST: cfg.row_first      <= pwdata[ROW_W-1:0];
        REG_ROW_LAST:  cfg.row_last       <= pwdata[ROW_W-1:0];
        REG_COLUMNS:   cfg.columns_in_use <= pwdata[NCOL_W-1:0];
        REG_ROWS:      cfg.rows_in_use    <= pwdata[NROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_FIRST: prdata = DATA_W'(cfg.row_first);
      REG_ROW_LAST:  prdata = DATA_W'(cfg.row_last);
      REG_COLUMNS:   prdata = DATA_W'(cfg.columns_in_use);
      REG_ROWS:      prdata = DATA_W'(cfg.rows_in_use);
      default:       prdata = '0;
    endcase
  end

endmodule

### design/srsp_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module srsp_div #(
  parameter int NUM_W = 37
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [NUM_W-1:0]              num,
  input  logic [srsp_pkg::ROWCNT_W-1:0] den,
  output logic                          busy,
  output logic                          done,
  output logic [NUM_W-1:0]              quot
);
  import srsp_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [ROWCNT_W-1:0] rem;
  logic [ROWCNT_W-1:0] den_q;
  logic [CNT_W-1:0]    steps;
  logic [ROWCNT_W:0]   shifted;
  logic [ROWCNT_W:0]   trial;

  assign shifted = {rem, quot[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && steps == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
      steps <= CNT_W'(NUM_W);
    end else if (busy) begin
      steps <= steps - CNT_W'(1);
      if (!trial[ROWCNT_W]) begin
        rem  <= trial[ROWCNT_W-1:0];
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[ROWCNT_W-1:0];
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

### design/shifted_row_sum_projection_top.sv
// top level of the shifted row-sum projection block
// Each input word either writes one pixel into the image memory, writes one
// row's signed column shift, or asks for one projected column. Pixel and
// shift writes give no result. A column read walks the rows
// row_first..row_last through the memories one row per cycle: the shift
// table read, then the image read at column + shift, then accumulation.
// The sum is then multiplied by the nominal row count and divided by the
// contributing row count in a bit-serial divider whose quotient is
// PIXEL_BITS + 21 bits wide (37 at 16-bit pixels). A bad row range or
// column skips the walk and answers with status set and projected 0;
// a read with no contributing row answers after the walk with projected 0.
// The result sits in an output register, so the next word is accepted while
// a result still waits. The shift table clears at reset through per-row
// valid bits; the image memory has no reset and must be written before read.
module shifted_row_sum_projection_top #(
  parameter int MAX_COLUMNS = srsp_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = srsp_pkg::MAX_ROWS_DEF,
  parameter int PIXEL_BITS  = srsp_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srsp_pkg::FUNC_W-1:0]   func,
  input  logic [srsp_pkg::COL_W-1:0]    column,
  input  logic [srsp_pkg::ROW_W-1:0]    row,
  input  logic [srsp_pkg::PIX_W-1:0]    pixel,
  input  logic signed [srsp_pkg::SHIFT_W-1:0] shift,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srsp_pkg::COL_W-1:0]    out_column,
  output logic [srsp_pkg::PROJ_W-1:0]   projected,
  output logic [srsp_pkg::STATUS_W-1:0] status,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [srsp_pkg::DATA_W-1:0]   pwdata,
  output logic [srsp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import srsp_pkg::*;

  // index widths of the memories
  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CXW = (CW > COL_W) ? CW : COL_W;
  localparam int RXW = (RW > ROW_W) ? RW : ROW_W;
  localparam int PXW = (PIXEL_BITS > PIX_W) ? PIXEL_BITS : PIX_W;
  localparam int IMG_DEPTH = 2 ** (RW + CW);

  // arithmetic widths
  localparam int SUM_W  = PIXEL_BITS + SUM_EXTRA;
  localparam int PROD_W = SUM_W + ROWCNT_W;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int QXW    = (NUM_W > PROJ_W) ? NUM_W : PROJ_W;
  localparam int SRC_W  = SHIFT_W + 2;

  localparam logic [8:0]  MAX_ROWS_V = 9'(MAX_ROWS);
  localparam logic [12:0] MAX_COLS_V = 13'(MAX_COLUMNS);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WALK   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_LAUNCH = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  cfg_t cfg;

  srsp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [2:0] state;
  logic       in_acc;

  // no word is taken while reset is held
  assign in_ready = !rst && (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // effective image size, capped at the memory size
  logic [8:0]  rows_ext;
  logic [8:0]  nrows;
  logic [12:0] cols_ext;
  logic [12:0] ncols;
  logic        range_bad;
  logic        col_bad;

  assign rows_ext  = 9'(cfg.rows_in_use);
  assign nrows     = (rows_ext < MAX_ROWS_V) ? rows_ext : MAX_ROWS_V;
  assign cols_ext  = 13'(cfg.columns_in_use);
  assign ncols     = (cols_ext < MAX_COLS_V) ? cols_ext : MAX_COLS_V;
  assign range_bad = (9'(cfg.row_first) >= nrows) || (9'(cfg.row_last) >= nrows) ||
                     (cfg.row_first > cfg.row_last);
  assign col_bad   = 13'(column) >= ncols;

  // write decode for incoming words
  logic [CXW-1:0]        col_x;
  logic [RXW-1:0]        row_x;
  logic [PXW-1:0]        pix_x;
  logic                  col_fits;
  logic                  row_fits;
  logic                  img_we;
  logic                  shift_we;

  assign col_x    = CXW'(column);
  assign row_x    = RXW'(row);
  assign pix_x    = PXW'(pixel);
  assign col_fits = 13'(column) < MAX_COLS_V;
  assign row_fits = 9'(row) < MAX_ROWS_V;
  assign img_we   = in_acc && (func == FUNC_PIXEL) && col_fits && row_fits;
  assign shift_we = in_acc && (func == FUNC_SHIFT) && row_fits;

  // walk pipeline registers
  logic [COL_W-1:0]    req_col;
  logic [ROW_W-1:0]    walk_row;
  logic                issue_active;
  logic                s1_valid;
  logic [RW-1:0]       s1_row;
  logic                s2_valid;
  logic [SUM_W-1:0]    sum;
  logic [ROWCNT_W-1:0] cnt;
  logic [RXW-1:0]      walk_row_x;

  assign walk_row_x = RXW'(walk_row);

  // shift table: one read port, cleared at reset through valid bits
  logic [SHIFT_W-1:0]  shift_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] shift_valid;
  logic [SHIFT_W-1:0]  shift_q;
  logic                shift_vq;
  logic [SHIFT_W-1:0]  shift_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_valid <= '0;
    end else if (shift_we) begin
      shift_valid[row_x[RW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_we) begin
      shift_mem[row_x[RW-1:0]] <= shift;
    end
    shift_q  <= shift_mem[walk_row_x[RW-1:0]];
    shift_vq <= shift_valid[walk_row_x[RW-1:0]];
  end

  // never-written rows read as zero shift
  assign shift_eff = shift_vq ? shift_q : '0;

  // source column of the row in stage 1 and its range test
  logic [SRC_W-1:0] src;
  logic             src_ok;

  assign src    = SRC_W'(req_col) + {{(SRC_W-SHIFT_W){shift_eff[SHIFT_W-1]}}, shift_eff};
  assign src_ok = !src[SRC_W-1] && (src[SRC_W-2:0] < ncols);

  // image memory, row index above column index
  logic [PIXEL_BITS-1:0] image_mem [IMG_DEPTH];
  logic [PIXEL_BITS-1:0] img_q;

  always_ff @(posedge clk) begin
    if (img_we) begin
      image_mem[{row_x[RW-1:0], col_x[CW-1:0]}] <= pix_x[PIXEL_BITS-1:0];
    end
    img_q <= image_mem[{s1_row, src[CW-1:0]}];
  end

  // scaling and division
  logic [ROWCNT_W-1:0] nominal;
  logic [PROD_W-1:0]   prod;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [NUM_W-1:0]    div_quot;
  logic [QXW-1:0]      quot_x;
  logic [PROJ_W-1:0]   quot_sat;

  assign nominal   = ROWCNT_W'(cfg.row_last) - ROWCNT_W'(cfg.row_first) + ROWCNT_W'(1);
  assign div_start = (state == ST_LAUNCH);
  assign quot_x    = QXW'(div_quot);
  assign quot_sat  = (quot_x > QXW'(PROJ_MAX)) ? PROJ_MAX : quot_x[PROJ_W-1:0];

  srsp_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({prod, {FRAC_BITS{1'b0}}}),
    .den   (cnt),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // pending result
  logic [PROJ_W-1:0]   res_proj;
  logic [STATUS_W-1:0] res_status;
  logic                out_load;

  assign out_load = (state == ST_FIN) && (!out_valid || out_ready);

  // sequencer and walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issue_active <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && (func == FUNC_READ)) begin
            if (range_bad || col_bad) begin
              state <= ST_FIN;
            end else begin
              state        <= ST_WALK;
              issue_active <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          // stage 0 issues a shift read, stage 1 an image read
          s1_valid <= issue_active;
          s2_valid <= s1_valid && src_ok;
          if (issue_active && (walk_row == cfg.row_last)) begin
            issue_active <= 1'b0;
          end
          if (!issue_active && !s1_valid && !s2_valid) begin
            state <= (cnt == '0) ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL:    state <= ST_LAUNCH;
        ST_LAUNCH: state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (in_acc && (func == FUNC_READ)) begin
      req_col    <= column;
      walk_row   <= cfg.row_first;
      sum        <= '0;
      cnt        <= '0;
      res_proj   <= '0;
      res_status <= range_bad ? STATUS_BAD_RANGE :
                    (col_bad ? STATUS_BAD_COL : STATUS_OK);
    end else begin
      if (state == ST_WALK) begin
        if (issue_active) begin
          walk_row <= walk_row + ROW_W'(1);
          s1_row   <= walk_row_x[RW-1:0];
        end
        if (s2_valid) begin
          sum <= sum + SUM_W'(img_q);
          cnt <= cnt + ROWCNT_W'(1);
        end
      end
      if (state == ST_MUL) begin
        prod <= PROD_W'(sum) * PROD_W'(nominal);
      end
      if ((state == ST_DIV) && div_done) begin
        res_proj <= quot_sat;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_column <= req_col;
      projected  <= res_proj;
      status     <= res_status;
    end
  end

endmodule

### design/srsp_checker.sv
// port-level checks of the projection block and their binding
module srsp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [srsp_pkg::FUNC_W-1:0]   func,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [srsp_pkg::COL_W-1:0]    out_column,
  input logic [srsp_pkg::PROJ_W-1:0]   projected,
  input logic [srsp_pkg::STATUS_W-1:0] status
);
  import srsp_pkg::*;

  // an error result carries no projection
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_OK)) |-> (projected == '0))
    else $error("error result with nonzero projection");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == STATUS_OK) || (status == STATUS_BAD_RANGE) ||
                   (status == STATUS_BAD_COL)))
    else $error("undefined status code");

  // a column read leaves the block busy: in_ready drops once the read is accepted
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (func == FUNC_READ)) |=> !in_ready)
    else $error("input accepted right after a column read");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_column) &&
                                   $stable(projected) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind shifted_row_sum_projection_top srsp_checker u_srsp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .func       (func),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_column (out_column),
  .projected  (projected),
  .status     (status)
);

### tb/projection_checker.sv
`timescale 1ns / 1ps
// checker that mirrors the projection block, predicts each column result and compares it
module projection_checker
  import srsp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [FUNC_W-1:0]          func,
  input  logic [COL_W-1:0]           column,
  input  logic [ROW_W-1:0]           row,
  input  logic [PIX_W-1:0]           pixel,
  input  logic signed [SHIFT_W-1:0]  shift,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [COL_W-1:0]           out_column,
  input  logic [PROJ_W-1:0]          projected,
  input  logic [STATUS_W-1:0]        status,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  input  logic [DATA_W-1:0]          prdata,
  input  logic                       pready,
  output int                         errors,
  output int                         pending
);

  localparam int NUM_COLS = MAX_COLUMNS_DEF;
  localparam int NUM_ROWS = MAX_ROWS_DEF;

  typedef struct {
    logic [COL_W-1:0]    col;
    logic [PROJ_W-1:0]   proj;
    logic [STATUS_W-1:0] stat;
  } column_result_t;

  logic [PIX_W-1:0]          image_mem [0:NUM_COLS*NUM_ROWS-1];
  logic signed [SHIFT_W-1:0] shift_mem [0:NUM_ROWS-1];
  cfg_t                      cfg_mirror;
  column_result_t            expected_columns [$];
  int                        err_count = 0;

  // shifted row sum over the configured range, scaled to the nominal row count
  function automatic column_result_t project_column(logic [COL_W-1:0] col);
    column_result_t res;
    int nrows, ncols, first, last, src, hits;
    longint sum, nominal, quot;
    nrows = (int'(cfg_mirror.rows_in_use) < NUM_ROWS) ? int'(cfg_mirror.rows_in_use) : NUM_ROWS;
    ncols = (int'(cfg_mirror.columns_in_use) < NUM_COLS) ?
            int'(cfg_mirror.columns_in_use) : NUM_COLS;
    first = int'(cfg_mirror.row_first);
    last  = int'(cfg_mirror.row_last);
    res.col  = col;
    res.proj = '0;
    res.stat = STATUS_OK;
    if (first >= nrows || last >= nrows || first > last) begin
      res.stat = STATUS_BAD_RANGE;
    end else if (int'(col) >= ncols) begin
      res.stat = STATUS_BAD_COL;
    end else begin
      sum = 0;
      hits = 0;
      nominal = last - first + 1;
      for (int j = first; j <= last; j++) begin
        src = int'(col) + int'(shift_mem[j]);
        if (src >= 0 && src < ncols) begin
          sum += image_mem[j*NUM_COLS + src];
          hits++;
        end
      end
      if (hits != 0) begin
        quot = (sum * nominal * (longint'(1) << FRAC_BITS)) / hits;
        if (quot > longint'(PROJ_MAX)) quot = longint'(PROJ_MAX);
        res.proj = quot[PROJ_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    column_result_t want;
    logic [DATA_W-1:0] reg_value;
    if (rst) begin
      expected_columns.delete();
      foreach (shift_mem[i]) shift_mem[i] = '0;
      cfg_mirror = {RESET_ROW_FIRST, RESET_ROW_LAST, RESET_COLUMNS, RESET_ROWS};
    end else begin
      // results first: a word accepted at this edge cannot answer at the same edge
      if (out_valid && out_ready) begin
        if (expected_columns.size() == 0) begin
          $error("result word with nothing expected: out_column %0d projected %0d status %0d",
                 out_column, projected, status);
          err_count++;
        end else begin
          want = expected_columns.pop_front();
          if (out_column !== want.col) begin
            $error("out_column mismatch: expected %0d, actual %0d", want.col, out_column);
            err_count++;
          end
          if (projected !== want.proj) begin
            $error("projected mismatch: expected %0d, actual %0d", want.proj, projected);
            err_count++;
          end
          if (status !== want.stat) begin
            $error("status mismatch: expected %0d, actual %0d", want.stat, status);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (func)
          FUNC_PIXEL: image_mem[{row, column}] = pixel;
          FUNC_SHIFT: shift_mem[row] = shift;
          FUNC_READ:  expected_columns.push_back(project_column(column));
          default: ;
        endcase
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_ROW_FIRST: cfg_mirror.row_first      = pwdata[ROW_W-1:0];
            REG_ROW_LAST:  cfg_mirror.row_last       = pwdata[ROW_W-1:0];
            REG_COLUMNS:   cfg_mirror.columns_in_use = pwdata[NCOL_W-1:0];
            REG_ROWS:      cfg_mirror.rows_in_use    = pwdata[NROW_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[ADDR_W-1:2])
            REG_ROW_FIRST: reg_value = DATA_W'(cfg_mirror.row_first);
            REG_ROW_LAST:  reg_value = DATA_W'(cfg_mirror.row_last);
            REG_COLUMNS:   reg_value = DATA_W'(cfg_mirror.columns_in_use);
            default:       reg_value = DATA_W'(cfg_mirror.rows_in_use);
          endcase
          if (prdata !== reg_value) begin
            $error("prdata mismatch at paddr %0d: expected %0d, actual %0d",
                   paddr, reg_value, prdata);
            err_count++;
          end
        end
      end
    end
    errors  <= err_count;
    pending <= expected_columns.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus and verdict for the shifted row-sum projection block
module tb;
  import srsp_pkg::*;

  localparam int DRAIN_CYCLES    = 128;
  localparam int RANDOM_PHASES   = 9;
  localparam int WORDS_PER_PHASE = 16;
  // columns written in every row before anything is read
  localparam int FILL_COLS       = 8;
  // the one function code the block ignores
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [FUNC_W-1:0]         func = '0;
  logic [COL_W-1:0]          column = '0;
  logic [ROW_W-1:0]          row = '0;
  logic [PIX_W-1:0]          pixel = '0;
  logic signed [SHIFT_W-1:0] shift = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [COL_W-1:0]          out_column;
  logic [PROJ_W-1:0]         projected;
  logic [STATUS_W-1:0]       status;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  int fail_count;
  int pending_count;
  // idle chances in percent for the sending and the receiving side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // live setting as the stimulus sees it, row and column counts capped
  int cur_first = int'(RESET_ROW_FIRST);
  int cur_last  = int'(RESET_ROW_LAST);
  int cur_cols  = MAX_COLUMNS_DEF;
  int cur_rows  = MAX_ROWS_DEF;
  // which pixels hold data and which shifts are set, so reads stay on written pixels
  bit pix_written [MAX_ROWS_DEF * MAX_COLUMNS_DEF];
  int tb_shift [MAX_ROWS_DEF];

  shifted_row_sum_projection_top DUT (.*);

  projection_checker u_checker (
    .errors  (fail_count),
    .pending (pending_count),
    .*
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random, at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // hard stop, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL shifted_row_sum_projection_top");
    $finish;
  end

  // present one word, with a random gap ahead of it, and hold it until taken
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [COL_W-1:0] c,
                           input logic [ROW_W-1:0] r, input logic [PIX_W-1:0] p,
                           input logic signed [SHIFT_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    column   <= c;
    row      <= r;
    pixel    <= p;
    shift    <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    case (f)
      FUNC_PIXEL: pix_written[int'(r) * MAX_COLUMNS_DEF + int'(c)] = 1'b1;
      FUNC_SHIFT: tb_shift[r] = int'(s);
      default: ;
    endcase
  endtask

  // first unwritten pixel that a read of column c would sum, or -1
  function automatic int missing_source(input int c);
    int src;
    if (cur_first >= cur_rows || cur_last >= cur_rows || cur_first > cur_last) return -1;
    if (c >= cur_cols) return -1;
    for (int j = cur_first; j <= cur_last; j++) begin
      src = c + tb_shift[j];
      if (src >= 0 && src < cur_cols && !pix_written[j * MAX_COLUMNS_DEF + src]) begin
        return j * MAX_COLUMNS_DEF + src;
      end
    end
    return -1;
  endfunction

  // write whatever pixels the read still lacks, then ask for the column
  task automatic read_column(input logic [COL_W-1:0] c);
    int idx;
    idx = missing_source(int'(c));
    while (idx >= 0) begin
      send_word(FUNC_PIXEL, COL_W'(idx % MAX_COLUMNS_DEF), ROW_W'(idx / MAX_COLUMNS_DEF),
                PIX_W'($urandom), '0);
      idx = missing_source(int'(c));
    end
    send_word(FUNC_READ, c, '0, '0, '0);
  endtask

  // wait out every expected result, then the tail of any write still in flight
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one apb transfer: setup, access, then idle so transfers never touch
  task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // the checker compares each readback against its own register copy
  task automatic read_back_all();
    apb_access(1'b0, REG_ROW_FIRST, '0);
    apb_access(1'b0, REG_ROW_LAST, '0);
    apb_access(1'b0, REG_COLUMNS, '0);
    apb_access(1'b0, REG_ROWS, '0);
  endtask

  // registers change only with the block idle
  task automatic set_config(input int first, input int last, input int cols, input int rows);
    drain();
    apb_access(1'b1, REG_ROW_FIRST, DATA_W'(first));
    apb_access(1'b1, REG_ROW_LAST, DATA_W'(last));
    apb_access(1'b1, REG_COLUMNS, DATA_W'(cols));
    apb_access(1'b1, REG_ROWS, DATA_W'(rows));
    read_back_all();
    cur_first = first & 63;
    cur_last  = last & 63;
    cur_cols  = ((cols & 2047) > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : (cols & 2047);
    cur_rows  = ((rows & 127) > MAX_ROWS_DEF) ? MAX_ROWS_DEF : (rows & 127);
  endtask

  // a legal row range inside a legal row count, narrow image
  task automatic random_config();
    int first, last;
    first = $urandom_range(40);
    last  = first + $urandom_range(63 - first);
    set_config(first, last, $urandom_range(FILL_COLS, 1), $urandom_range(64, last + 1));
  endtask

  // mostly writes and reads that hit the live image, a little noise
  task automatic random_word();
    logic [FUNC_W-1:0]         f;
    logic [COL_W-1:0]          c;
    logic [ROW_W-1:0]          r;
    logic [PIX_W-1:0]          p;
    logic signed [SHIFT_W-1:0] s;
    int pick;
    int idx;
    f = FUNC_UNUSED;
    c = COL_W'($urandom);
    r = ROW_W'($urandom);
    p = PIX_W'($urandom);
    s = SHIFT_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      f = FUNC_PIXEL;
      if ($urandom_range(9) == 0) p = $urandom_range(1) ? '1 : '0;
    end else if (pick < 55) begin
      f = FUNC_SHIFT;
      case ($urandom_range(3))
        // small curvature keeps most rows contributing
        0: s = SHIFT_W'(int'($urandom_range(40)) - 20);
        1: ;
        // around the image width, so rows drop out at the edges
        2: s = SHIFT_W'(int'($urandom_range(2 * cur_cols)) - cur_cols);
        default: s = $urandom_range(1) ? 12'sh7ff : 12'sh800;
      endcase
    end else if (pick < 95) begin
      f = FUNC_READ;
      case ($urandom_range(9))
        0: c = '0;
        1: c = COL_W'(cur_cols - 1);
        2: c = COL_W'(cur_cols);
        3: c = '1;
        4, 5: ;
        default: if (cur_cols > 0) c = COL_W'($urandom_range(cur_cols - 1));
      endcase
      // a read that would sum an unwritten pixel writes that pixel instead
      idx = missing_source(int'(c));
      if (idx >= 0) begin
        f = FUNC_PIXEL;
        c = COL_W'(idx % MAX_COLUMNS_DEF);
        r = ROW_W'(idx / MAX_COLUMNS_DEF);
      end
    end
    send_word(f, c, r, p, s);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_back_all();

    // a narrow stripe of every row first; wider reads fill their pixels on demand
    for (int r = 0; r < MAX_ROWS_DEF; r++) begin
      for (int c = 0; c < FILL_COLS; c++) begin
        send_word(FUNC_PIXEL, COL_W'(c), ROW_W'(r), PIX_W'($urandom), '0);
      end
    end

    // directed words under the reset setting
    send_idle_pct = 36;
    recv_idle_pct = 51;
    send_word(FUNC_PIXEL, '0, '0, '1, '0);
    send_word(FUNC_PIXEL, '1, '1, '0, '0);
    send_word(FUNC_PIXEL, '0, 6'd5, '1, '0);
    send_word(FUNC_PIXEL, '1, 6'd58, '1, '0);
    send_word(FUNC_SHIFT, '0, 6'd6, '0, 12'sh800);
    send_word(FUNC_SHIFT, '0, 6'd7, '0, 12'sh7ff);
    send_word(FUNC_SHIFT, '0, 6'd8, '0, 12'sd1);
    send_word(FUNC_SHIFT, '0, 6'd9, '0, -12'sd1);
    // ignored function code with busy fields
    send_word(FUNC_UNUSED, '1, '1, '1, '1);
    read_column('0);
    read_column('1);
    read_column(10'd512);

    // one row only: shifts that push the source off either side leave no row
    set_config(5, 5, 1024, 64);
    send_word(FUNC_SHIFT, '0, 6'd5, '0, 12'sh7ff);
    read_column(10'd1000);
    read_column('0);
    send_word(FUNC_SHIFT, '0, 6'd5, '0, 12'sh800);
    read_column('1);
    send_word(FUNC_SHIFT, '0, 6'd5, '0, '0);
    read_column('0);

    // last row beyond the rows in use
    set_config(0, 40, 1024, 32);
    read_column('0);
    // first row after last row
    set_config(3, 2, 1024, 64);
    read_column(10'd5);
    // no columns at all
    set_config(0, 5, 0, 64);
    read_column('0);
    // column just past and just inside the columns in use
    set_config(0, 63, FILL_COLS, 64);
    read_column(COL_W'(FILL_COLS));
    read_column(COL_W'(FILL_COLS - 1));
    // no rows at all
    set_config(0, 0, 1024, 0);
    read_column('0);

    // random phases: receiver-heavy idling, then sender-heavy, then none
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph / 3)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph)
        0: set_config(0, 63, FILL_COLS, 64);
        1: set_config(0, 0, 1, 1);
        3: set_config(63, 63, 1024, 64);
        // counts above the caps
        4: set_config(10, 20, 2047, 127);
        6: set_config(0, 63, FILL_COLS / 2, 64);
        7: set_config(3, 2, 1024, 64);
        8: set_config(0, 63, 1024, 64);
        default: random_config();
      endcase
      repeat (WORDS_PER_PHASE) random_word();
    end

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS shifted_row_sum_projection_top");
    end else begin
      $display("FAIL shifted_row_sum_projection_top");
    end
    $finish;
  end

endmodule
